[sv/assert_macros.svh]
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lgc_pkg.sv]
// ----------------------------------------------------------------------------
// lgc_pkg
// Shared widths and types for the line gradient color pipeline.
// ----------------------------------------------------------------------------
package lgc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS + 1;
  localparam int Q_BITS     = 2 * FRAC_BITS;
  localparam int T_BITS     = FRAC_BITS + 1;
  localparam int CH_BITS    = 8;
  localparam int COLOR_BITS = 3 * CH_BITS;

  typedef logic [SQ_BITS-1:0]    sq_t;
  typedef logic [Q_BITS-1:0]     quo_t;
  typedef logic [FRAC_BITS-1:0]  root_t;
  typedef logic [T_BITS-1:0]     ratio_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // Per-item side data traveling with the pipeline.
  typedef struct packed {
    logic   zero_len;
    logic   sat;
    color_t sc;
    color_t ec;
  } side_t;

endpackage

[sv/lgc_div.sv]
// ----------------------------------------------------------------------------
// lgc_div
// Pipelined restoring divider: quotient of cur_sq*2^(2F)/total_sq,
// one quotient bit per stage, valid only when cur_sq < total_sq.
// ----------------------------------------------------------------------------
module lgc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  lgc_pkg::sq_t        in_num,
  input  lgc_pkg::sq_t        in_den,
  input  lgc_pkg::side_t      in_side,
  output logic                out_vld,
  output lgc_pkg::quo_t       out_quo,
  output lgc_pkg::side_t      out_side
);

  localparam int N = lgc_pkg::Q_BITS;
  localparam int RW = lgc_pkg::SQ_BITS + 1;

  logic [RW-1:0]          rem_r [N+1];
  lgc_pkg::sq_t           den_r [N+1];
  lgc_pkg::quo_t          quo_r [N+1];
  lgc_pkg::side_t         side_r[N+1];
  logic                   vld_r [N+1];

  assign rem_r[0]  = {1'b0, in_num};
  assign den_r[0]  = in_den;
  assign quo_r[0]  = '0;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_vld;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem_r[i][RW-2:0], 1'b0};
    assign ge = sh >= {1'b0, den_r[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      rem_r[i+1]  <= ge ? (sh - {1'b0, den_r[i]}) : sh;
      den_r[i+1]  <= den_r[i];
      quo_r[i+1]  <= {quo_r[i][N-2:0], ge};
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld  = vld_r[N];
  assign out_quo  = quo_r[N];
  assign out_side = side_r[N];

endmodule

[sv/lgc_sqrt.sv]
// ----------------------------------------------------------------------------
// lgc_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lgc_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  lgc_pkg::quo_t       in_rad,
  input  lgc_pkg::side_t      in_side,
  output logic                out_vld,
  output lgc_pkg::root_t      out_root,
  output lgc_pkg::side_t      out_side
);

  localparam int N  = lgc_pkg::FRAC_BITS;
  localparam int RW = lgc_pkg::FRAC_BITS + 2;

  lgc_pkg::quo_t   rad_r [N+1];
  logic [RW-1:0]   rem_r [N+1];
  lgc_pkg::root_t  root_r[N+1];
  lgc_pkg::side_t  side_r[N+1];
  logic            vld_r [N+1];

  assign rad_r[0]  = in_rad;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_vld;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] cand;
    logic [RW-1:0] trial;
    logic          ge;
    assign cand  = {rem_r[i][RW-3:0], rad_r[i][2*N-1 -: 2]};
    assign trial = {root_r[i], 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      rem_r[i+1]  <= ge ? (cand - trial) : cand;
      root_r[i+1] <= {root_r[i][N-2:0], ge};
      rad_r[i+1]  <= {rad_r[i][2*N-3:0], 2'b00};
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = root_r[N];
  assign out_side = side_r[N];

endmodule

[sv/lgc_blend.sv]
// ----------------------------------------------------------------------------
// lgc_blend
// Per-channel blend of start and end colors by ratio t, two stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lgc_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  lgc_pkg::root_t      in_root,
  input  lgc_pkg::side_t      in_side,
  output logic                out_vld,
  output lgc_pkg::color_t     out_color
);

  localparam int CB = lgc_pkg::CH_BITS;
  localparam int PB = CB + lgc_pkg::T_BITS;

  // stage 1: products
  logic [PB-1:0]     prod_r [3];
  logic              up_r [3];
  lgc_pkg::color_t   sc_r;
  logic              pass_r;
  logic              vld1_r;
  lgc_pkg::ratio_t   t;

  assign t = in_side.sat ? lgc_pkg::ratio_t'(1) << lgc_pkg::FRAC_BITS
                         : {1'b0, in_root};

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [CB-1:0] s, e, mag;
    assign s = in_side.sc[c*CB +: CB];
    assign e = in_side.ec[c*CB +: CB];
    assign mag = (e >= s) ? e - s : s - e;
    always_ff @(posedge clk) begin
      prod_r[c] <= PB'(mag) * PB'(t);
      up_r[c]   <= e >= s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      out_vld <= vld1_r;
    end
    sc_r   <= in_side.sc;
    pass_r <= in_side.zero_len;
  end

  // stage 2: apply
  lgc_pkg::color_t col_nxt;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CB-1:0] m;
      m = prod_r[c][lgc_pkg::FRAC_BITS +: CB];
      col_nxt[c*CB +: CB] = up_r[c] ? sc_r[c*CB +: CB] + m : sc_r[c*CB +: CB] - m;
    end
  end

  always_ff @(posedge clk) begin
    out_color <= pass_r ? sc_r : col_nxt;
  end

  `ASSERT_NEXT(a_vld_flow, clk, rst_n, vld1_r, out_vld, "blend valid lost")
  `ASSERT_IMP(a_ratio_max, clk, rst_n, in_vld && !in_side.sat,
              t <= (lgc_pkg::ratio_t'(1) << lgc_pkg::FRAC_BITS), "ratio out of range")

endmodule

[sv/line_gradient_color_top.sv]
// ----------------------------------------------------------------------------
// line_gradient_color_top
// Color of a point on a segment, interpolated by distance ratio.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel: drive in_* with start high; a transfer happens at each
//  edge where start is high and busy is low. busy is tied low: a new
//  point may enter in every cycle.
//  Result channel: out_valid pulses for one cycle with out_pixel_color.
//  The receiver cannot stall, and does not need to.
//  Pipeline: a squaring register, a sum/compare register, 32 divider stages
//  (one quotient bit each), 16 square-root stages (one root bit each),
//  and 2 blend stages.
//  Throughput: one item per cycle, set by the fully pipelined divider
//  and square root.
//  Zero-length segment returns start color; a point at or beyond the
//  segment length saturates t to 1.0 and returns end color.
//  Reset (rst_n low, synchronous) clears all valid bits; items in flight
//  are dropped. There is no configuration.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_gradient_color_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            in_start_x,
  input  logic signed [15:0]            in_start_y,
  input  logic signed [15:0]            in_end_x,
  input  logic signed [15:0]            in_end_y,
  input  logic signed [15:0]            in_cur_x,
  input  logic signed [15:0]            in_cur_y,
  input  logic [23:0]                   in_start_color,
  input  logic [23:0]                   in_end_color,
  output logic                          out_valid,
  output logic [23:0]                   out_pixel_color
);

  localparam int DB = lgc_pkg::DIFF_BITS;
  localparam int MB = lgc_pkg::COORD_BITS;

  assign busy = 1'b0;

  // stage A: absolute differences squared
  logic [DB-1:0] dex, dey, dcx, dcy;
  logic [MB-1:0] mex, mey, mcx, mcy;
  always_comb begin
    dex = {in_end_x[15], in_end_x} - {in_start_x[15], in_start_x};
    dey = {in_end_y[15], in_end_y} - {in_start_y[15], in_start_y};
    dcx = {in_cur_x[15], in_cur_x} - {in_start_x[15], in_start_x};
    dcy = {in_cur_y[15], in_cur_y} - {in_start_y[15], in_start_y};
    mex = MB'(dex[DB-1] ? -dex : dex);
    mey = MB'(dey[DB-1] ? -dey : dey);
    mcx = MB'(dcx[DB-1] ? -dcx : dcx);
    mcy = MB'(dcy[DB-1] ? -dcy : dcy);
  end

  logic [2*MB-1:0] sqex_r, sqey_r, sqcx_r, sqcy_r;
  lgc_pkg::color_t sca_r, eca_r;
  logic            vlda_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r <= 1'b0;
    end else begin
      vlda_r <= start && !busy;
    end
    sqex_r <= mex * mex;
    sqey_r <= mey * mey;
    sqcx_r <= mcx * mcx;
    sqcy_r <= mcy * mcy;
    sca_r  <= in_start_color;
    eca_r  <= in_end_color;
  end

  // stage B: sums and special-case flags
  lgc_pkg::sq_t   tot, cur;
  lgc_pkg::sq_t   totb_r, curb_r;
  lgc_pkg::side_t sideb_r;
  logic           vldb_r;

  assign tot = lgc_pkg::SQ_BITS'(sqex_r) + lgc_pkg::SQ_BITS'(sqey_r);
  assign cur = lgc_pkg::SQ_BITS'(sqcx_r) + lgc_pkg::SQ_BITS'(sqcy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldb_r <= 1'b0;
    end else begin
      vldb_r <= vlda_r;
    end
    totb_r           <= tot;
    // saturated items divide 0 by total so the divider stays well defined
    curb_r           <= (cur >= tot) ? '0 : cur;
    sideb_r.zero_len <= tot == '0;
    sideb_r.sat      <= cur >= tot;
    sideb_r.sc       <= sca_r;
    sideb_r.ec       <= eca_r;
  end

  logic           div_vld, sq_vld;
  lgc_pkg::quo_t  quo;
  lgc_pkg::root_t root;
  lgc_pkg::side_t div_side, sq_side;

  lgc_div u_div (
    .clk(clk), .rst_n(rst_n),
    .in_vld(vldb_r), .in_num(curb_r), .in_den(totb_r), .in_side(sideb_r),
    .out_vld(div_vld), .out_quo(quo), .out_side(div_side)
  );

  lgc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n),
    .in_vld(div_vld), .in_rad(quo), .in_side(div_side),
    .out_vld(sq_vld), .out_root(root), .out_side(sq_side)
  );

  lgc_blend u_blend (
    .clk(clk), .rst_n(rst_n),
    .in_vld(sq_vld), .in_root(root), .in_side(sq_side),
    .out_vld(out_valid), .out_color(out_pixel_color)
  );

  `ASSERT_NEXT(a_accept, clk, rst_n, start, vlda_r, "transfer not captured")
  `ASSERT_IMP(a_busy, clk, rst_n, 1'b1, !busy, "busy asserted")
  `ASSERT_IMP(a_zero_sat, clk, rst_n, vldb_r && sideb_r.zero_len, sideb_r.sat,
              "zero length not saturated")

endmodule

[sim/lgc_checker.sv]
// ----------------------------------------------------------------------------
// lgc_checker
// Watches the point transfers and the color results, predicts each pixel
// color in fixed point and compares it with the block's output in order.
// ----------------------------------------------------------------------------
module lgc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic signed [15:0] in_cur_x,
  input  logic signed [15:0] in_cur_y,
  input  logic [23:0]        in_start_color,
  input  logic [23:0]        in_end_color,
  input  logic               out_valid,
  input  logic [23:0]        out_pixel_color,
  output int                 n_fail,
  output int                 n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0] color_q[$];

  assign n_pending = color_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      b = root | (64'd1 << i);
      if (b * b <= v) root = b;
    end
    return root;
  endfunction

  function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] e, logic [16:0] t);
    logic [63:0] span;
    if (e >= s) begin
      span = ((64'(e - s)) * t) >> 16;
      return s + span[7:0];
    end
    span = ((64'(s - e)) * t) >> 16;
    return s - span[7:0];
  endfunction

  function automatic logic [23:0] gradient_color(
      logic signed [15:0] sx, logic signed [15:0] sy,
      logic signed [15:0] ex, logic signed [15:0] ey,
      logic signed [15:0] cx, logic signed [15:0] cy,
      logic [23:0] sc, logic [23:0] ec);
    longint dx, dy, px, py;
    logic [63:0] len_sq, pt_sq, quot;
    logic [16:0] t;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    px = longint'(cx) - longint'(sx);
    py = longint'(cy) - longint'(sy);
    len_sq = dx * dx + dy * dy;
    pt_sq  = px * px + py * py;
    if (len_sq == 0) return sc;
    if (pt_sq >= len_sq) begin
      t = 17'h10000;
    end else begin
      // pt_sq < 2^33, so the shift fits in 65+ bits only via 128-bit math
      quot = 64'(({64'd0, pt_sq} << 32) / {64'd0, len_sq});
      t = 17'(int_sqrt(quot));
    end
    return {mix_chan(sc[23:16], ec[23:16], t), mix_chan(sc[15:8], ec[15:8], t),
            mix_chan(sc[7:0], ec[7:0], t)};
  endfunction

  initial n_fail = 0;

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      color_q.push_back(gradient_color(in_start_x, in_start_y, in_end_x, in_end_y,
                                       in_cur_x, in_cur_y, in_start_color, in_end_color));
    if (rst_n && out_valid) begin
      if (color_q.size() == 0) begin
        $error("pixel_color: unexpected result %h", out_pixel_color);
        n_fail <= n_fail + 1;
      end else if (color_q[0] !== out_pixel_color) begin
        $error("pixel_color: expected %h actual %h", color_q[0], out_pixel_color);
        n_fail <= n_fail + 1;
        void'(color_q.pop_front());
      end else begin
        void'(color_q.pop_front());
      end
    end
  end
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives points and segments into the gradient color block with random
// gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] sx = '0, sy = '0, ex = '0, ey = '0, cx = '0, cy = '0;
  logic [23:0] sc = '0, ec = '0;
  logic out_valid;
  logic [23:0] out_pixel_color;
  int n_fail, n_pending;
  int idle_pct;

  always #2 clk = ~clk;

  line_gradient_color_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(sx), .in_start_y(sy), .in_end_x(ex), .in_end_y(ey),
    .in_cur_x(cx), .in_cur_y(cy), .in_start_color(sc), .in_end_color(ec),
    .out_valid(out_valid), .out_pixel_color(out_pixel_color)
  );

  lgc_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(sx), .in_start_y(sy), .in_end_x(ex), .in_end_y(ey),
    .in_cur_x(cx), .in_cur_y(cy), .in_start_color(sc), .in_end_color(ec),
    .out_valid(out_valid), .out_pixel_color(out_pixel_color),
    .n_fail(n_fail), .n_pending(n_pending)
  );

  // One transfer: optional idle cycles first, then hold start until taken.
  task automatic send_point(input logic [15:0] a, b, c, d, e, f, input logic [23:0] g, h);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    sx <= a; sy <= b; ex <= c; ey <= d; cx <= e; cy <= f; sc <= g; ec <= h;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Coordinate: mostly small offsets so t spans the whole ramp, sometimes full range.
  function automatic logic [15:0] rnd_coord(logic [15:0] base);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return base + 16'($signed($urandom_range(400)) - 200);
  endfunction

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [15:0] bx, by, qx, qy;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero length, beyond end, exact midpoint, extreme corners.
    send_point(16'd5, 16'd5, 16'd5, 16'd5, 16'd9, 16'd9, 24'h123456, 24'hABCDEF);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 24'hFFFFFF, 24'h0);
    send_point(16'h0, 16'h0, 16'd10, 16'd0, 16'd20, 16'd0, 24'h000000, 24'hFFFFFF);
    send_point(16'h0, 16'h0, 16'd10, 16'd0, 16'd5, 16'd0, 24'h000000, 24'hFFFFFF);
    send_point(16'h0, 16'h0, 16'd10, 16'd0, 16'd5, 16'd0, 24'hFFFFFF, 24'h000000);
    send_point(16'h0, 16'h0, 16'd10, 16'd0, 16'd0, 16'd0, 24'hFF00FF, 24'h00FF00);
    send_point(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 24'h0F0F0F, 24'hF0F0F0);
    send_point(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 24'hFFFFFF, 24'h0);
    send_point(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 24'hA5A5A5, 24'h5A5A5A);
    send_point(16'h0, 16'h0, 16'd1, 16'd1, 16'd1, 16'd0, 24'h000000, 24'hFFFFFF);
    send_point(16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h8000, 16'h7FFF, 24'h808080, 24'h7F7F7F);

    // Random phases: none, sender idle 61%, 38%, then none again.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 61 : (ph == 2) ? 38 : 0;
      repeat (385) begin
        bx = 16'($urandom); by = 16'($urandom);
        qx = rnd_coord(bx); qy = rnd_coord(by);
        send_point(bx, by, qx, qy, rnd_coord(bx), rnd_coord(by),
                   24'($urandom), 24'($urandom));
      end
    end
    start <= 1'b0;

    // Drain: wait until no result is still pending.
    for (int w = 0; w < 2000 && n_pending != 0; w++) @(posedge clk);
    repeat (60) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/lgc_pkg.sv
sv/lgc_div.sv
sv/lgc_sqrt.sv
sv/lgc_blend.sv
sv/line_gradient_color_top.sv
sim/lgc_checker.sv
sim/tb_top.sv
